[rtl/md4_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// md4_pkg
// Types, constants and round tables shared by the MD4 digest engine.
// ----------------------------------------------------------------------------
package md4_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } md4_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md4_out_t;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_COMP = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_OUT  = 5'b10000
  } md4_state_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [31:0] K_ROUND2 = 32'h5A827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ED9EBA1;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam int unsigned NUM_ROUNDS = 48;
  localparam logic [3:0] LEN_WORD_LO = 4'd14;
  localparam logic [3:0] LEN_WORD_HI = 4'd15;

  localparam logic [3:0] WORD_ORDER [NUM_ROUNDS] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
    4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15,
    4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
    4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15
  };

  localparam logic [4:0] SHIFT_AMT [NUM_ROUNDS] = '{
    5'd3, 5'd7, 5'd11, 5'd19, 5'd3, 5'd7, 5'd11, 5'd19,
    5'd3, 5'd7, 5'd11, 5'd19, 5'd3, 5'd7, 5'd11, 5'd19,
    5'd3, 5'd5, 5'd9, 5'd13, 5'd3, 5'd5, 5'd9, 5'd13,
    5'd3, 5'd5, 5'd9, 5'd13, 5'd3, 5'd5, 5'd9, 5'd13,
    5'd3, 5'd9, 5'd11, 5'd15, 5'd3, 5'd9, 5'd11, 5'd15,
    5'd3, 5'd9, 5'd11, 5'd15, 5'd3, 5'd9, 5'd11, 5'd15
  };

endpackage
`default_nettype wire

[rtl/md4_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// md4_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module md4_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire                          clk,
  input  wire                          we,
  input  wire [$clog2(DEPTH)-1:0]      waddr,
  input  wire [WIDTH-1:0]              wdata,
  input  wire [$clog2(DEPTH)-1:0]      raddr,
  output logic [WIDTH-1:0]             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/md4_hash_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// md4_hash_engine
// Streaming MD4 digest: absorbs one byte per transaction, a finish transaction
// pads the message and returns the digest as four 32-bit words A..D.
// ----------------------------------------------------------------------------
// Flow: each data byte is taken in the idle state; the 64th byte of a block
//   starts the compression (one round per cycle through the block RAM read
//   port, then the chaining add). No byte is taken until the block is done.
// Finish: per padded block (one or two), up to 16 pad writes, the rounds and
//   the chaining add, then four result transactions, one per cycle when taken.
// Reset: clears chaining words to the MD4 initial values, offset and bit count
//   to zero; the block RAM holds no reset value and needs none.
// ----------------------------------------------------------------------------
module md4_hash_engine (
  input  wire               clk,
  input  wire               rst,
  input  wire               data_valid,
  output logic              data_ready,
  input  md4_pkg::md4_in_t  data,
  output logic              result_valid,
  input  wire               result_ready,
  output md4_pkg::md4_out_t result
);

  md4_pkg::md4_state_t state;
  logic [31:0] chain [4];
  logic [31:0] ra, rb, rc, rd;
  logic [23:0] acc;
  logic [5:0]  byte_offset;
  logic [63:0] bit_count;
  logic [3:0]  pad_idx;
  logic        fin;
  logic        len_blk;
  logic [5:0]  cnt;
  logic [1:0]  out_idx;

  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;

  logic        in_fire;
  logic        out_fire;
  logic [31:0] pad_word;
  logic [3:0]  cur_word;
  logic [5:0]  rnd;
  logic [31:0] f_val;
  logic [31:0] t_val;
  logic [63:0] t_dbl;
  logic [31:0] b_next;

  assign data_ready   = (state == md4_pkg::ST_IDLE);
  assign in_fire      = data_valid && data_ready;
  assign result_valid = (state == md4_pkg::ST_OUT);
  assign out_fire     = result_valid && result_ready;
  assign cur_word     = byte_offset[5:2];

  assign result.digest_word = chain[out_idx];
  assign result.word_index  = out_idx;
  assign result.last_word   = (out_idx == 2'd3);

  // Word holding the 0x80 marker and the bytes already collected before it
  always_comb begin
    unique case (byte_offset[1:0])
      2'd0:    pad_word = {24'h0, md4_pkg::PAD_BYTE};
      2'd1:    pad_word = {16'h0, md4_pkg::PAD_BYTE, acc[7:0]};
      2'd2:    pad_word = {8'h0, md4_pkg::PAD_BYTE, acc[15:0]};
      default: pad_word = {md4_pkg::PAD_BYTE, acc[23:0]};
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_word;
    ram_wdata = {data.data_byte, acc};
    if (in_fire) begin
      if (data.op == md4_pkg::OP_FINISH) begin
        ram_we    = 1'b1;
        ram_wdata = pad_word;
      end else begin
        ram_we = (byte_offset[1:0] == 2'd3);
      end
    end else if (state == md4_pkg::ST_PAD) begin
      ram_we    = 1'b1;
      ram_waddr = pad_idx;
      if (len_blk && pad_idx == md4_pkg::LEN_WORD_LO) begin
        ram_wdata = bit_count[31:0];
      end else if (len_blk && pad_idx == md4_pkg::LEN_WORD_HI) begin
        ram_wdata = bit_count[63:32];
      end else begin
        ram_wdata = 32'h0;
      end
    end
  end

  // Round cnt-1 executes while the read for round cnt is issued
  assign ram_raddr = (cnt < 6'(md4_pkg::NUM_ROUNDS)) ? md4_pkg::WORD_ORDER[cnt]
                                                     : 4'd0;
  assign rnd = cnt - 6'd1;

  always_comb begin
    if (rnd < 6'd16) begin
      f_val = (rb & rc) | (~rb & rd);
    end else if (rnd < 6'd32) begin
      f_val = ((rb & rc) | (rb & rd) | (rc & rd)) + md4_pkg::K_ROUND2;
    end else begin
      f_val = (rb ^ rc ^ rd) + md4_pkg::K_ROUND3;
    end
    t_val  = ra + f_val + ram_rdata;
    t_dbl  = {t_val, t_val} << md4_pkg::SHIFT_AMT[rnd];
    b_next = t_dbl[63:32];
  end

  md4_ram #(
    .WIDTH(32),
    .DEPTH(16)
  ) u_block_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= md4_pkg::ST_IDLE;
      chain[0]    <= md4_pkg::IV_A;
      chain[1]    <= md4_pkg::IV_B;
      chain[2]    <= md4_pkg::IV_C;
      chain[3]    <= md4_pkg::IV_D;
      byte_offset <= 6'd0;
      bit_count   <= 64'd0;
      fin         <= 1'b0;
      len_blk     <= 1'b0;
      cnt         <= 6'd0;
      pad_idx     <= 4'd0;
      out_idx     <= 2'd0;
    end else begin
      unique case (state)
        md4_pkg::ST_IDLE: begin
          if (in_fire) begin
            ra  <= chain[0];
            rb  <= chain[1];
            rc  <= chain[2];
            rd  <= chain[3];
            cnt <= 6'd0;
            if (data.op == md4_pkg::OP_ABSORB) begin
              acc[8*byte_offset[1:0] +: 8] <= data.data_byte;
              byte_offset <= byte_offset + 6'd1;
              bit_count   <= bit_count + 64'd8;
              fin         <= 1'b0;
              if (byte_offset == 6'd63) begin
                state <= md4_pkg::ST_COMP;
              end
            end else begin
              fin     <= 1'b1;
              len_blk <= (cur_word < md4_pkg::LEN_WORD_LO);
              pad_idx <= cur_word + 4'd1;
              // marker landed in the last word: block is already full
              if (cur_word == md4_pkg::LEN_WORD_HI) begin
                state <= md4_pkg::ST_COMP;
              end else begin
                state <= md4_pkg::ST_PAD;
              end
            end
          end
        end
        md4_pkg::ST_PAD: begin
          pad_idx <= pad_idx + 4'd1;
          if (pad_idx == md4_pkg::LEN_WORD_HI) begin
            ra    <= chain[0];
            rb    <= chain[1];
            rc    <= chain[2];
            rd    <= chain[3];
            cnt   <= 6'd0;
            state <= md4_pkg::ST_COMP;
          end
        end
        md4_pkg::ST_COMP: begin
          if (cnt != 6'd0) begin
            ra <= rd;
            rd <= rc;
            rc <= rb;
            rb <= b_next;
          end
          if (cnt == 6'(md4_pkg::NUM_ROUNDS)) begin
            state <= md4_pkg::ST_ADD;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        md4_pkg::ST_ADD: begin
          chain[0] <= chain[0] + ra;
          chain[1] <= chain[1] + rb;
          chain[2] <= chain[2] + rc;
          chain[3] <= chain[3] + rd;
          cnt      <= 6'd0;
          if (!fin) begin
            state <= md4_pkg::ST_IDLE;
          end else if (!len_blk) begin
            // second block carries zeros and the length
            len_blk <= 1'b1;
            pad_idx <= 4'd0;
            state   <= md4_pkg::ST_PAD;
          end else begin
            out_idx <= 2'd0;
            state   <= md4_pkg::ST_OUT;
          end
        end
        md4_pkg::ST_OUT: begin
          if (out_fire) begin
            out_idx <= out_idx + 2'd1;
            if (out_idx == 2'd3) begin
              chain[0]    <= md4_pkg::IV_A;
              chain[1]    <= md4_pkg::IV_B;
              chain[2]    <= md4_pkg::IV_C;
              chain[3]    <= md4_pkg::IV_D;
              byte_offset <= 6'd0;
              bit_count   <= 64'd0;
              fin         <= 1'b0;
              state       <= md4_pkg::ST_IDLE;
            end
          end
        end
        default: begin
          state <= md4_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Round counter never runs past the last round
  assert property (@(posedge clk) disable iff (rst)
    cnt <= 6'(md4_pkg::NUM_ROUNDS))
    else $error("round counter out of range");

  // A full block must start compression
  assert property (@(posedge clk) disable iff (rst)
    in_fire && data.op == md4_pkg::OP_ABSORB && byte_offset == 6'd63
    |=> state == md4_pkg::ST_COMP)
    else $error("full block did not start compression");

  // After the last digest word the engine is back to a fresh message
  assert property (@(posedge clk) disable iff (rst)
    out_fire && result.last_word
    |=> byte_offset == 6'd0 && bit_count == 64'd0 && chain[0] == md4_pkg::IV_A
        && chain[3] == md4_pkg::IV_D && data_ready)
    else $error("engine not reinitialized after digest");

  // Results and new input transactions never overlap
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !data_ready)
    else $error("input accepted while digest pending");

endmodule
`default_nettype wire
